/* hdl/step_dir_pulse_generator_macros.svh */
// -----------------------------------------------------------------------------
// step_dir_pulse_generator_macros - assertion helpers
// shared concurrent assertion forms, sampled on the rising clock edge
// -----------------------------------------------------------------------------
`ifndef STEP_DIR_PULSE_GENERATOR_MACROS_SVH
`define STEP_DIR_PULSE_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SDPG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdpg assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SDPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdpg assertion failed");

`endif

/* hdl/sdpg_pkg.sv */
// -----------------------------------------------------------------------------
// sdpg_pkg
// types and constants of the step and direction pulse generator
// -----------------------------------------------------------------------------
package sdpg_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 5;
    localparam int DIR_BIT      = 31;

    typedef logic [POS_W-1:0]  t_pin_pos;
    typedef logic [WORD_W-1:0] t_word;

    // input item function codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // register index bit 0 picks step or direction position, bits 2..1 the channel
    localparam logic CFG_SEL_STEP = 1'b0;
    localparam logic CFG_SEL_DIR  = 1'b1;

    localparam t_pin_pos STEP_POS_RESET [MAX_CHANNELS] = '{5'd5, 5'd15, 5'd0, 5'd0};
    localparam t_pin_pos DIR_POS_RESET  [MAX_CHANNELS] = '{5'd2, 5'd14, 5'd0, 5'd0};

    // pin levels of one channel
    typedef struct packed {
        logic step;
        logic dir;
    } t_chan_pins;

endpackage

/* hdl/sdpg_channel.sv */
// -----------------------------------------------------------------------------
// sdpg_channel
// one channel: period word, last toggle timestamp and step level
// -----------------------------------------------------------------------------
module sdpg_channel
    import sdpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_write,
    input  t_word      i_period_value,
    input  logic       i_tick,
    input  t_word      i_total_next,
    output t_chan_pins o_pins
);

    t_word r_period;
    t_word r_last;
    logic  r_level;

    logic  w_enable;
    t_word w_diff;
    logic  w_toggle;
    logic  w_level_now;

    assign w_enable    = (r_period != '0);
    assign w_diff      = i_total_next - r_last;
    assign w_toggle    = w_enable && (w_diff > {1'b0, r_period[DIR_BIT-1:0]});
    assign w_level_now = r_level ^ w_toggle;

    assign o_pins.step = w_enable & w_level_now;
    assign o_pins.dir  = w_enable & r_period[DIR_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_last   <= '0;
            r_level  <= 1'b0;
        end else begin
            if (i_write) begin
                r_period <= i_period_value;
            end
            if (i_tick && w_toggle) begin
                r_level <= ~r_level;
                r_last  <= i_total_next;
            end
        end
    end

endmodule

/* hdl/step_dir_pulse_generator.sv */
// -----------------------------------------------------------------------------
// step_dir_pulse_generator
// multi-channel step and direction generator with a 32-bit pin word result
// -----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry func, channel, period_value
//   and elapsed_cycles. a write item (func 1) loads a channel period word and
//   gives no result. a tick item (func 0) advances the cycle total, toggles
//   every enabled channel whose interval has passed and gives one pin word.
//   output channel: o_out_valid / i_out_stall carry o_pin_word.
//   config channel: i_cfg_valid / o_cfg_ready with a 3-bit register index
//   (step/dir pin position per channel) and 5-bit data; always ready.
//   result: a tick's pin word is registered in the output register, or in the
//   skid register on a stall. throughput: one item per cycle while o_in_stall
//   is low; all channel compares run in parallel in a single pass, so the
//   cycle total add plus the per-channel subtract and compare set the critical path.
//   stall: an output register plus a skid register keep input transfers going
//   after the receiver stalls; o_in_stall rises only once the skid register
//   holds a word.
//   reset: synchronous active low; all channels disabled, cycle total zero,
//   pin positions back to their reset defaults, both result registers empty.
// -----------------------------------------------------------------------------
`include "step_dir_pulse_generator_macros.svh"

module step_dir_pulse_generator
    import sdpg_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [1:0]  i_channel,
    input  logic [31:0] i_period_value,
    input  logic [31:0] i_elapsed_cycles,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pin_word,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    // pin position registers, one step and one direction position per channel
    t_pin_pos r_step_pos [MAX_CHANNELS];
    t_pin_pos r_dir_pos  [MAX_CHANNELS];

    t_word r_cycle_total;
    t_word n_cycle_total;

    // result register and skid register
    logic  r_out_valid;
    t_word r_pin_word;
    logic  r_skid_valid;
    t_word r_skid_word;

    logic       w_in_xfer;
    logic       w_tick;
    logic       w_out_xfer;
    t_word      w_word;
    t_chan_pins w_pins [NUM_CHANNELS];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_pin_word  = r_pin_word;

    assign w_in_xfer  = i_in_valid && !r_skid_valid;
    assign w_tick     = w_in_xfer && (i_func == FUNC_TICK);
    assign w_out_xfer = r_out_valid && !i_out_stall;

    assign n_cycle_total = r_cycle_total + i_elapsed_cycles;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_pos <= STEP_POS_RESET;
            r_dir_pos  <= DIR_POS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index[0] == CFG_SEL_DIR) begin
                r_dir_pos[i_cfg_index[2:1]] <= i_cfg_data;
            end else begin
                r_step_pos[i_cfg_index[2:1]] <= i_cfg_data;
            end
        end
    end

    // running cycle total, modulo 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_total <= '0;
        end else if (w_tick) begin
            r_cycle_total <= n_cycle_total;
        end
    end

    // channels; a write to a channel that is not built is dropped
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
        sdpg_channel u_chan (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_write        (w_in_xfer && (i_func == FUNC_WRITE) && (i_channel == 2'(g))),
            .i_period_value (i_period_value),
            .i_tick         (w_tick),
            .i_total_next   (n_cycle_total),
            .o_pins         (w_pins[g])
        );
    end

    // merge channel pins into the pin word, shared positions OR together
    always_comb begin
        w_word = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            w_word = w_word | (t_word'(w_pins[i].step) << r_step_pos[i]);
            w_word = w_word | (t_word'(w_pins[i].dir) << r_dir_pos[i]);
        end
    end

    // result and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled, only drain
            if (w_out_xfer) begin
                r_pin_word   <= r_skid_word;
                r_skid_valid <= 1'b0;
            end
        end else if (w_tick) begin
            if (!r_out_valid || w_out_xfer) begin
                r_pin_word  <= w_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_word  <= w_word;
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // checks
    `SDPG_ASSERT_IMPLY(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SDPG_ASSERT_NEXT(a_stalled_tick_to_skid, i_clk, i_rst_n,
        w_tick && r_out_valid && i_out_stall, r_skid_valid && r_out_valid)
    `SDPG_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n,
        w_in_xfer && (i_func == FUNC_WRITE) && !w_out_xfer,
        r_out_valid == $past(r_out_valid) && !r_skid_valid)

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb - step and direction pulse generator testbench
// drives period writes and time ticks with random sender gaps and receiver
// stalls, predicts every pin word and compares it in order with the block
// -----------------------------------------------------------------------------

// tracks channel state and pin positions and holds the pin words still due
class pin_word_scoreboard;
    sdpg_pkg::t_pin_pos step_pos [sdpg_pkg::MAX_CHANNELS];
    sdpg_pkg::t_pin_pos dir_pos  [sdpg_pkg::MAX_CHANNELS];
    sdpg_pkg::t_word    cycle_total;
    sdpg_pkg::t_word    period_word  [sdpg_pkg::MAX_CHANNELS];
    sdpg_pkg::t_word    toggle_stamp [sdpg_pkg::MAX_CHANNELS];
    bit                 step_level   [sdpg_pkg::MAX_CHANNELS];
    sdpg_pkg::t_word    pin_words_due[$];
    int                 errors;

    function void clear();
        for (int i = 0; i < sdpg_pkg::MAX_CHANNELS; i++) begin
            step_pos[i]     = sdpg_pkg::STEP_POS_RESET[i];
            dir_pos[i]      = sdpg_pkg::DIR_POS_RESET[i];
            period_word[i]  = '0;
            toggle_stamp[i] = '0;
            step_level[i]   = 1'b0;
        end
        cycle_total = '0;
        pin_words_due.delete();
    endfunction

    // index bits 2..1 pick the channel, bit 0 step or direction
    function void write_position(logic [2:0] index, sdpg_pkg::t_pin_pos pos);
        if (index[0] == sdpg_pkg::CFG_SEL_STEP) begin
            step_pos[index[2:1]] = pos;
        end else begin
            dir_pos[index[2:1]] = pos;
        end
    endfunction

    // a write loads a period word, a tick advances time and yields a pin word
    function void note_item(logic func, logic [1:0] chan, sdpg_pkg::t_word period,
                            sdpg_pkg::t_word elapsed);
        sdpg_pkg::t_word since, word;
        bit step, dir;
        if (func == sdpg_pkg::FUNC_WRITE) begin
            period_word[chan] = period;
            return;
        end
        cycle_total = cycle_total + elapsed;
        word = '0;
        for (int i = 0; i < sdpg_pkg::MAX_CHANNELS; i++) begin
            step = 1'b0;
            dir  = 1'b0;
            if (period_word[i] != '0) begin
                dir   = period_word[i][sdpg_pkg::DIR_BIT];
                since = cycle_total - toggle_stamp[i];
                if (since > {1'b0, period_word[i][30:0]}) begin
                    step_level[i]   = ~step_level[i];
                    toggle_stamp[i] = cycle_total;
                end
                step = step_level[i];
            end
            word |= sdpg_pkg::t_word'(step) << step_pos[i];
            word |= sdpg_pkg::t_word'(dir) << dir_pos[i];
        end
        pin_words_due.push_back(word);
    endfunction

    task check_pin_word(logic [31:0] got);
        sdpg_pkg::t_word want;
        if (pin_words_due.size() == 0) begin
            report("pin word with none due", got, '0);
        end else begin
            want = pin_words_due.pop_front();
            if (got !== want) begin
                report("pin word", got, want);
            end
        end
    endtask

    task report(string what, logic [31:0] got, sdpg_pkg::t_word want);
        errors++;
        if (errors <= 25) begin
            $display("mismatch: %s got %08h expected %08h", what, got, want);
        end
    endtask

    function int pending();
        return pin_words_due.size();
    endfunction
endclass

module tb;
    import sdpg_pkg::*;

    localparam int SETTLE_CYCLES    = 4;     // result latency plus skid, with margin
    localparam int IDLE_LIMIT       = 2000;  // cycles with no transfer on any channel
    localparam int HOLD_CYCLES      = 60;    // long receiver hold-off
    localparam int HOLD_ITEMS       = 50;    // ticks offered back to back during it
    localparam int ITEMS_PER_PHASE  = 238;   // items per position setting
    localparam int NUM_PHASES       = 6;

    typedef struct {
        logic       func;
        logic [1:0] chan;
        t_word      period;
        t_word      elapsed;
    } t_gen_item;

    // all block inputs start at known values
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        func         = FUNC_TICK;
    logic [1:0]  chan         = '0;
    logic [31:0] period_value = '0;
    logic [31:0] elapsed      = '0;
    logic        out_stall    = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [4:0]  cfg_data     = '0;

    logic        in_stall;
    logic        out_valid;
    logic [31:0] pin_word;
    logic        cfg_ready;

    pin_word_scoreboard sb = new();

    int idle_cycles   = 0;
    int burst_left    = 0;
    int hold_requests = 0;  // bumped by the sender, served by the receiver
    bit moved;

    step_dir_pulse_generator #(
        .NUM_CHANNELS(MAX_CHANNELS)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (func),
        .i_channel       (chan),
        .i_period_value  (period_value),
        .i_elapsed_cycles(elapsed),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_pin_word      (pin_word),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // transfers are seen at the rising edge; result checked before the input
    // of the same edge is noted, since a result always comes from an older tick
    always @(posedge clk) begin
        if (rst_n) begin
            moved = 1'b0;
            if (out_valid && !out_stall) begin
                sb.check_pin_word(pin_word);
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_position(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (in_valid && !in_stall) begin
                sb.note_item(func, chan, period_value, elapsed);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog: nothing moving for too long means a hang or a lost result
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stall pattern: free runs, random stalls, solid stall stretches,
    // and a long hold-off whenever the sender asks for one
    initial begin : receiver
        int seg_left   = 0;
        int seg_mode   = 0;
        int hold_count = 0;
        int holds_done = 0;
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                out_stall <= 1'b1;
                hold_count++;
                if (hold_count == HOLD_CYCLES) begin
                    hold_count = 0;
                    holds_done++;
                end
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 2);
                    seg_left = (seg_mode == 2) ? $urandom_range(1, 12)
                                               : $urandom_range(5, 60);
                end
                seg_left--;
                case (seg_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 40);
                    default: out_stall <= 1'b1;
                endcase
            end
        end
    end

    function automatic t_gen_item item_of(logic f, logic [1:0] c, t_word p, t_word e);
        t_gen_item it;
        it.func    = f;
        it.chan    = c;
        it.period  = p;
        it.elapsed = e;
        return it;
    endfunction

    // mostly small intervals and small elapsed counts so channels toggle often;
    // now and then full-range words for wrap and every bit
    function automatic t_gen_item random_item();
        t_gen_item it;
        int        pick;
        it.chan    = 2'($urandom_range(0, 3));
        it.period  = $urandom;
        it.elapsed = $urandom;
        if ($urandom_range(0, 99) < 18) begin
            it.func = FUNC_WRITE;
            pick    = $urandom_range(0, 9);
            if (pick == 0) begin
                it.period = '0;
            end else if (pick == 1) begin
                it.period = 32'h8000_0000;
            end else if (pick > 2) begin
                it.period      = t_word'($urandom_range(0, 60));
                it.period[DIR_BIT] = 1'($urandom_range(0, 1));
            end
        end else begin
            it.func = FUNC_TICK;
            pick    = $urandom_range(0, 19);
            if (pick == 1) begin
                it.elapsed = '0;
            end else if (pick > 1) begin
                it.elapsed = t_word'($urandom_range(1, 30));
            end
        end
        return it;
    endfunction

    // one input transfer; valid stays up until the block takes it
    task automatic put_item(t_gen_item it);
        @(negedge clk);
        in_valid     <= 1'b1;
        func         <= it.func;
        chan         <= it.chan;
        period_value <= it.period;
        elapsed      <= it.elapsed;
        do @(posedge clk); while (in_stall);
    endtask

    // payload is junk while valid is low
    task automatic idle_input(int cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid     <= 1'b0;
            func         <= 1'($urandom);
            chan         <= 2'($urandom);
            period_value <= $urandom;
            elapsed      <= $urandom;
        end
    endtask

    // sender runs in bursts with random gaps in between
    task automatic offer(t_gen_item it);
        put_item(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_input($urandom_range(0, 10));
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // sender pause until every pin word is back and the pipe is empty
    task automatic drain_results();
        idle_input(1);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pin positions of one setting: all low, all high, spread out, random
    task automatic write_positions(int phase);
        for (int idx = 0; idx < 2 * MAX_CHANNELS; idx++) begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= 3'(idx);
            case (phase)
                1:       cfg_data <= 5'd0;
                2:       cfg_data <= 5'd31;
                3:       cfg_data <= 5'(idx * 4 + 3);
                default: cfg_data <= 5'($urandom_range(0, 31));
            endcase
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_items();
        // all channels disabled: word is zero
        offer(item_of(FUNC_TICK, 2'd0, '0, '0));
        // zero interval with direction set: toggles on any nonzero step of time
        offer(item_of(FUNC_WRITE, 2'd0, 32'h8000_0000, '0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd1));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd0));
        // widest interval, short interval, all-ones word
        offer(item_of(FUNC_WRITE, 2'd1, 32'h7fff_ffff, '0));
        offer(item_of(FUNC_WRITE, 2'd2, 32'd3, '0));
        offer(item_of(FUNC_WRITE, 2'd3, 32'hffff_ffff, '0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd3));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd1));
        // counter wrap
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'hffff_ffff));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'h8000_0000));
        // disable keeps level and stamp, pins go low; re-enable picks them up
        offer(item_of(FUNC_WRITE, 2'd2, '0, '0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd7));
        offer(item_of(FUNC_WRITE, 2'd2, 32'd5, '0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd2));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'hffff_fff0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'h0000_0020));
        // interval one: toggles only once the time since the last toggle exceeds one
        offer(item_of(FUNC_WRITE, 2'd0, 32'd1, '0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd1));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd1));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd2));
        // the reset positions of channels 2 and 3 share bit 0
        offer(item_of(FUNC_WRITE, 2'd3, 32'h8000_0002, '0));
        offer(item_of(FUNC_TICK, 2'd0, '0, 32'd9));
    endtask

    initial begin : stimulus
        sb.clear();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_items();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                write_positions(phase);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 4) begin
                    drain_results();
                end
                // long hold-off while ticks keep coming: fills the output and
                // skid registers until the input stalls
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
                    hold_requests++;
                    repeat (HOLD_ITEMS) begin
                        put_item(item_of(FUNC_TICK, 2'd0, '0,
                                         t_word'($urandom_range(0, 30))));
                    end
                end
                offer(random_item());
            end
        end
        drain_results();

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
